### src/kvs_pkg.sv
// kvs_pkg: shared types, constants and helpers for the key velocity scanner
`timescale 1ns / 1ps

package kvs_pkg;

   localparam int CHANNELS    = 16;
   localparam int SAMPLE_BITS = 10;
   localparam int TIME_BITS   = 32;

   localparam int CH_W        = 4;
   localparam int VEL_W       = 7;
   localparam int STEP_W      = 8;
   localparam int TOL_W       = 6;
   localparam int SHIFT_W     = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int REQ_DATA_W  = ((CH_W + SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((CH_W + VEL_W + 7) / 8) * 8;

   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // levels carry one extra bit so peak plus step never wraps
   localparam int LVL_W       = SAMPLE_BITS + 1;
   localparam int SUM_W       = LVL_W + 3;
   localparam int DIV_K       = SUM_W + 3;
   localparam int RECIP_W     = DIV_K - 2;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((2 ** DIV_K) / 5 + 1);

   localparam logic [VEL_W-1:0] VEL_MAX = {VEL_W{1'b1}};

   // reset values of the registers
   localparam logic [STEP_W-1:0]  CAL_STEP_RST  = STEP_W'(20);
   localparam logic [TOL_W-1:0]   REST_TOL_RST  = TOL_W'(2);
   localparam logic [SHIFT_W-1:0] VEL_SHIFT_RST = SHIFT_W'(2);

   localparam logic [CSR_IDX_W-1:0] REG_CAL_STEP  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_REST_TOL  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_VEL_SHIFT = CSR_IDX_W'(2);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef enum logic [2:0] {
      MODE_REST    = 3'd0,
      MODE_CAL     = 3'd1,
      MODE_LOW     = 3'd2,
      MODE_HIGH    = 3'd3,
      MODE_RELEASE = 3'd4
   } key_mode_type;

   typedef struct packed {
      key_mode_type            mode;
      logic [SAMPLE_BITS-1:0]  rest;
      logic [LVL_W-1:0]        peak;
      logic [LVL_W-1:0]        low_thr;
      logic [LVL_W-1:0]        high_thr;
      logic [TIME_BITS-1:0]    start;
   } key_state_type;

   typedef struct packed {
      logic              valid;
      logic              on;
      logic [VEL_W-1:0]  velocity;
   } note_event_type;

   localparam key_state_type KEY_STATE_RST = '{
      mode:     MODE_REST,
      rest:     '0,
      peak:     '0,
      low_thr:  '0,
      high_thr: '0,
      start:    '0
   };

   // divide by five through a reciprocal multiply, exact while the quotient fits in LVL_W bits (inputs below 10240)
   function automatic logic [LVL_W-1:0] div5(input logic [SUM_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(RECIP_5);
      return prod[DIV_K +: LVL_W];
   endfunction

endpackage

### src/key_velocity_scanner.sv
// key_velocity_scanner: top level, item pipeline, channel state and register file
`timescale 1ns / 1ps

// Takes one word per cycle: a timer tick (tuser high) advances the shared time
// counter, a sample (tuser low) runs its channel's key state machine. A word
// sits in an input register, where the channel state is read, updated and
// written back, and any note event is registered in the result register.
// The block sustains one word per cycle through this read-modify-write of
// the channel state; it only stalls when the result register is full and
// not being taken. Thresholds use a reciprocal multiply for the divide by
// five.
module key_velocity_scanner (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // channel [3:0], sample [13:4], zero pad above
   input  logic [kvs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [0]
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // note_channel [3:0], note_velocity [10:4], zero pad above
   output logic [kvs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // note_on [0]
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_write_en,
   input  logic [kvs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kvs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kvs_pkg::*;

   logic [STEP_W-1:0]        cal_step_ff;
   logic [TOL_W-1:0]         rest_tol_ff;
   logic [SHIFT_W-1:0]       vel_shift_ff;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_kind_ff;
   logic [CH_W-1:0]          s1_channel_ff;
   logic [SAMPLE_BITS-1:0]   s1_sample_ff;

   logic [TIME_BITS-1:0]     tick_count_ff;
   key_state_type            key_state_ff [CHANNELS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]          rsp_channel_ff;
   logic                     rsp_on_ff;
   logic [VEL_W-1:0]         rsp_vel_ff;

   logic                     advance;
   logic                     s1_go;
   logic                     ch_ok;
   logic [CH_IDX_W-1:0]      ch_idx;
   logic                     sample_go;
   logic                     emit;
   key_state_type            cur_state;
   key_state_type            next_state;
   note_event_type           note_event;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_step_ff  <= CAL_STEP_RST;
         rest_tol_ff  <= REST_TOL_RST;
         vel_shift_ff <= VEL_SHIFT_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_CAL_STEP:  cal_step_ff  <= csr_wdata[STEP_W-1:0];
            REG_REST_TOL:  rest_tol_ff  <= csr_wdata[TOL_W-1:0];
            REG_VEL_SHIFT: vel_shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // the input word moves on whenever the result register can take a word
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff    <= req_tuser[0];
         s1_channel_ff <= req_tdata[CH_W-1:0];
         s1_sample_ff  <= req_tdata[CH_W +: SAMPLE_BITS];
      end
   end

   assign ch_ok     = int'(s1_channel_ff) < CHANNELS;
   assign ch_idx    = s1_channel_ff[CH_IDX_W-1:0];
   assign sample_go = s1_go && (s1_kind_ff == KIND_SAMPLE) && ch_ok;
   assign cur_state = key_state_ff[ch_idx];

   kvs_key_fsm u_key_fsm (
      .cur_state  (cur_state),
      .sample     (s1_sample_ff),
      .cal_step   (cal_step_ff),
      .rest_tol   (rest_tol_ff),
      .vel_shift  (vel_shift_ff),
      .tick_count (tick_count_ff),
      .next_state (next_state),
      .note_event (note_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
      end else if (s1_go && (s1_kind_ff == KIND_TICK)) begin
         tick_count_ff <= tick_count_ff + TIME_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            key_state_ff[i] <= KEY_STATE_RST;
         end
      end else if (sample_go) begin
         key_state_ff[ch_idx] <= next_state;
      end
   end

   // result register
   assign emit         = sample_go && note_event.valid;
   assign rsp_valid_in = advance ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_on_ff      <= note_event.on;
         rsp_vel_ff     <= note_event.velocity;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CH_W - VEL_W){1'b0}}, rsp_vel_ff, rsp_channel_ff};
   assign rsp_tuser  = rsp_on_ff;

   // a new result only comes from a sample word leaving the input register
   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && (s1_kind_ff == KIND_SAMPLE)))
      else $error("result appeared without a sample word");

   // note-off always carries zero velocity
   a_off_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_on_ff) |-> (rsp_vel_ff == '0))
      else $error("note-off with nonzero velocity");

   // the time counter only moves on a tick word
   a_tick_only: assert property (@(posedge clock) disable iff (reset)
      !(s1_go && (s1_kind_ff == KIND_TICK)) |=> $stable(tick_count_ff))
      else $error("time counter moved without a tick");

   // a word can never be taken into a full input register that is stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_channel_ff)))
      else $error("stalled input word lost");

endmodule

### src/kvs_key_fsm.sv
// kvs_key_fsm: next state and note event for one key channel and one sample
`timescale 1ns / 1ps

module kvs_key_fsm (
   input  kvs_pkg::key_state_type          cur_state,
   input  logic [kvs_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [kvs_pkg::STEP_W-1:0]      cal_step,
   input  logic [kvs_pkg::TOL_W-1:0]       rest_tol,
   input  logic [kvs_pkg::SHIFT_W-1:0]     vel_shift,
   input  logic [kvs_pkg::TIME_BITS-1:0]   tick_count,
   output kvs_pkg::key_state_type          next_state,
   output kvs_pkg::note_event_type         note_event
);
   import kvs_pkg::*;

   logic [LVL_W:0]           smp_ext;
   logic [LVL_W:0]           peak_ext;
   logic [LVL_W:0]           step_ext;
   logic                     rise;
   logic                     fall;
   logic [LVL_W-1:0]         peak_raised;
   logic [SUM_W-1:0]         low_sum;
   logic [SUM_W-1:0]         high_sum;
   logic [LVL_W-1:0]         smp_lvl;
   logic                     above_low;
   logic                     above_high;
   logic [SAMPLE_BITS-1:0]   rest_diff;
   logic                     near_rest;
   logic [TIME_BITS-1:0]     elapsed;
   logic [TIME_BITS-1:0]     scaled;
   logic [VEL_W-1:0]         velocity;

   assign smp_ext  = (LVL_W+1)'(sample);
   assign peak_ext = (LVL_W+1)'(cur_state.peak);
   assign step_ext = (LVL_W+1)'(cal_step);

   assign rise = smp_ext > (peak_ext + step_ext);
   assign fall = peak_ext > (smp_ext + step_ext);

   assign peak_raised = LVL_W'(peak_ext + step_ext);
   assign low_sum  = SUM_W'(peak_raised) + (SUM_W'(cur_state.rest) << 2);
   assign high_sum = (SUM_W'(peak_raised) << 2) + SUM_W'(cur_state.rest);

   assign smp_lvl    = LVL_W'(sample);
   assign above_low  = smp_lvl >= cur_state.low_thr;
   assign above_high = smp_lvl >= cur_state.high_thr;

   assign rest_diff = (sample >= cur_state.rest) ? (sample - cur_state.rest)
                                                 : (cur_state.rest - sample);
   assign near_rest = rest_diff < SAMPLE_BITS'(rest_tol);

   // time counter wraps, so the plain difference is the elapsed time
   assign elapsed  = tick_count - cur_state.start;
   assign scaled   = elapsed >> vel_shift;
   assign velocity = (|scaled[TIME_BITS-1:VEL_W]) ? VEL_MAX
                                                   : VEL_MAX - scaled[VEL_W-1:0];

   always_comb begin
      next_state = cur_state;
      case (cur_state.mode)
         MODE_REST: begin
            next_state.rest = sample;
            next_state.mode = MODE_CAL;
         end
         MODE_CAL: begin
            if (rise) begin
               next_state.peak = smp_lvl;
            end else if (fall) begin
               next_state.peak     = peak_raised;
               next_state.low_thr  = div5(low_sum);
               next_state.high_thr = div5(high_sum);
               next_state.mode     = MODE_RELEASE;
            end
         end
         MODE_LOW: begin
            if (above_low) begin
               next_state.start = tick_count;
               next_state.mode  = MODE_HIGH;
            end
         end
         MODE_HIGH: begin
            if (above_high) begin
               next_state.mode = MODE_RELEASE;
            end else if (!above_low) begin
               next_state.mode = MODE_LOW;
            end
         end
         default: begin
            if (near_rest) begin
               next_state.mode = MODE_LOW;
            end
         end
      endcase
   end

   always_comb begin
      note_event = '0;
      case (cur_state.mode)
         MODE_REST, MODE_CAL, MODE_LOW: begin
            note_event = '0;
         end
         MODE_HIGH: begin
            if (above_high) begin
               note_event.valid    = 1'b1;
               note_event.on       = 1'b1;
               note_event.velocity = velocity;
            end
         end
         default: begin
            if (near_rest) begin
               note_event.valid = 1'b1;
            end
         end
      endcase
   end

endmodule
